FILE: rtl/hadt_pkg.sv
// Shared types, command codes and butterfly functions for the Hadamard transform core.
package hadt_pkg;

    // Lane count of one segment and one coefficient group
    localparam int LANES = 8;

    // Command codes carried on the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Block size codes
    localparam logic [1:0] MODE_4  = 2'd0;
    localparam logic [1:0] MODE_8  = 2'd1;
    localparam logic [1:0] MODE_16 = 2'd2;
    localparam logic [1:0] MODE_32 = 2'd3;

    typedef logic signed [8:0]  t_res;
    typedef logic signed [15:0] t_coef;
    typedef t_res  [LANES-1:0]  t_res_row;
    typedef t_coef [LANES-1:0]  t_coef_row;

    // 8-point butterfly with permuted output order 0,7,3,4,2,6,1,5
    function automatic t_coef_row bfly8(t_coef_row v);
        t_coef     x [8];
        t_coef     b [8];
        t_coef     c [8];
        t_coef_row o;
        for (int n = 0; n < 8; n++) begin
            x[n] = v[n];
        end
        for (int n = 0; n < 4; n++) begin
            b[2*n]   = x[2*n] + x[2*n+1];
            b[2*n+1] = x[2*n] - x[2*n+1];
        end
        c[0] = b[0] + b[2];
        c[1] = b[1] + b[3];
        c[2] = b[0] - b[2];
        c[3] = b[1] - b[3];
        c[4] = b[4] + b[6];
        c[5] = b[5] + b[7];
        c[6] = b[4] - b[6];
        c[7] = b[5] - b[7];
        o[0] = c[0] + c[4];
        o[7] = c[1] + c[5];
        o[3] = c[2] + c[6];
        o[4] = c[3] + c[7];
        o[2] = c[0] - c[4];
        o[6] = c[1] - c[5];
        o[1] = c[2] - c[6];
        o[5] = c[3] - c[7];
        return o;
    endfunction

    // 4-point butterfly on lanes 0 to 3, halving after the first stage
    function automatic t_coef_row bfly4(t_coef_row v);
        t_coef     x [4];
        t_coef     b [4];
        t_coef_row o;
        for (int n = 0; n < 4; n++) begin
            x[n] = v[n];
        end
        b[0] = (x[0] + x[1]) >>> 1;
        b[1] = (x[0] - x[1]) >>> 1;
        b[2] = (x[2] + x[3]) >>> 1;
        b[3] = (x[2] - x[3]) >>> 1;
        o    = '0;
        o[0] = b[0] + b[2];
        o[1] = b[1] + b[3];
        o[2] = b[0] - b[2];
        o[3] = b[1] - b[3];
        return o;
    endfunction

endpackage

FILE: rtl/hadt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hadt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hadamard_2d_transform_core.sv
// Two-dimensional Hadamard transform core: segment loading, butterfly passes, read-out.
// Load request: written to the residual memory at the accepting edge. Read request: ready
// result registered in the cycle after acceptance, while a wait state blocks input; not-ready
// status registered at the accepting edge. New requests and configuration writes are blocked
// during the transform that follows the final segment.
// Reset (synchronous, active low) selects 8x8 and clears counters and the ready flag;
// the residual and coefficient memories are not cleared.
module hadamard_2d_transform_core
    import hadt_pkg::*;
#(
    parameter int MAX_BLOCK_SIDE = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write: block size code
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_data,
    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // residual_0 .. residual_7, 9 bits each
    input  logic         s_tuser,   // command
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // coef_0 .. coef_7, 16 bits each
    output logic         m_tlast,   // last_group
    output logic         m_tuser    // status
);

    localparam int RES_WORDS  = (MAX_BLOCK_SIDE * MAX_BLOCK_SIDE / LANES < 4) ? 4 :
                                MAX_BLOCK_SIDE * MAX_BLOCK_SIDE / LANES;
    localparam int COEF_WORDS = (MAX_BLOCK_SIDE * MAX_BLOCK_SIDE / LANES < 2) ? 2 :
                                MAX_BLOCK_SIDE * MAX_BLOCK_SIDE / LANES;
    localparam int RES_AW     = $clog2(RES_WORDS);
    localparam int COEF_AW    = $clog2(COEF_WORDS);
    localparam logic [1:0] MODE_MAX = (MAX_BLOCK_SIDE >= 32) ? MODE_32 :
                                      (MAX_BLOCK_SIDE >= 16) ? MODE_16 :
                                      (MAX_BLOCK_SIDE >= 8)  ? MODE_8  : MODE_4;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_TLOAD  = 4'd2;
    localparam logic [3:0] S_TWAIT  = 4'd3;
    localparam logic [3:0] S_TPASS  = 4'd4;
    localparam logic [3:0] S_TWRITE = 4'd5;
    localparam logic [3:0] S_CREAD  = 4'd6;
    localparam logic [3:0] S_CWAIT  = 4'd7;
    localparam logic [3:0] S_CWRITE = 4'd8;

    // Control registers
    logic [3:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic [7:0] r_seg, n_seg;
    logic [6:0] r_grp, n_grp;
    logic       r_ready, n_ready;
    logic [2:0] r_k, n_k;
    logic [3:0] r_tile, n_tile;
    logic [4:0] r_g, n_g;
    logic [1:0] r_j, n_j;
    logic       r_phase2, n_phase2;
    logic       r_m_valid, n_m_valid;

    // Payload registers
    t_res_row  r_rows [8];
    t_coef_row r_mid  [8];
    t_coef_row r_acc  [4];
    t_coef_row r_m_data;
    logic      r_m_last;
    logic      r_m_status;

    // Memory ports
    logic              res_we;
    logic [RES_AW-1:0] res_waddr, res_raddr;
    t_res_row          res_wdata, res_rdata;
    logic              coef_we;
    logic [COEF_AW-1:0] coef_waddr, coef_raddr;
    t_coef_row         coef_wdata, coef_rdata;

    logic [1:0] w_mode;
    logic [6:0] w_seg_last, w_grp_last;
    logic [3:0] w_tile_last;
    logic [4:0] w_g_last;
    logic [2:0] w_k_last, w_i_last;
    logic [6:0] w_tile_addr, w_comb_addr, w_row_addr;
    logic       w_s_acc, w_cfg_acc, w_out_free;
    t_res_row   w_clamped;
    t_coef_row  w_pass1 [8];
    t_coef_row  w_pass2;
    t_coef_row  w_comb  [4];

    hadt_ram #(.WIDTH($bits(t_res_row)), .DEPTH(RES_WORDS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    hadt_ram #(.WIDTH($bits(t_coef_row)), .DEPTH(COEF_WORDS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // Limit the size to what the memories hold
    assign w_mode = (r_mode > MODE_MAX) ? MODE_MAX : r_mode;

    // Per-size counts
    always_comb begin
        case (w_mode)
            MODE_4: begin
                w_seg_last = 7'd3;   w_grp_last = 7'd1;   w_tile_last = 4'd0;
                w_g_last   = 5'd0;   w_k_last   = 3'd3;   w_i_last    = 3'd1;
            end
            MODE_8: begin
                w_seg_last = 7'd7;   w_grp_last = 7'd7;   w_tile_last = 4'd0;
                w_g_last   = 5'd0;   w_k_last   = 3'd7;   w_i_last    = 3'd7;
            end
            MODE_16: begin
                w_seg_last = 7'd31;  w_grp_last = 7'd31;  w_tile_last = 4'd3;
                w_g_last   = 5'd7;   w_k_last   = 3'd7;   w_i_last    = 3'd7;
            end
            default: begin
                w_seg_last = 7'd127; w_grp_last = 7'd127; w_tile_last = 4'd15;
                w_g_last   = 5'd31;  w_k_last   = 3'd7;   w_i_last    = 3'd7;
            end
        endcase
    end

    // Residual row address of tile row r_k
    always_comb begin
        case (w_mode)
            MODE_16: w_tile_addr = {2'd0, r_tile[1], r_k, r_tile[0]};
            MODE_32: w_tile_addr = {r_tile[3], r_tile[1], r_k, r_tile[2], r_tile[0]};
            default: w_tile_addr = {4'd0, r_k};
        endcase
    end

    // Word address of combine operand r_j of group r_g
    assign w_comb_addr = r_phase2 ? {r_j, r_g} : {r_g[4:3], r_j, r_g[2:0]};

    // Word address of output row r_k of tile r_tile
    assign w_row_addr = {r_tile, r_k};

    // Clamp incoming residuals
    always_comb begin
        for (int n = 0; n < LANES; n++) begin
            w_clamped[n] = (s_tdata[9*n +: 9] == 9'h100) ? 9'h101 : s_tdata[9*n +: 9];
        end
    end

    // Column pass over the tile
    always_comb begin
        t_coef_row v;
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 8; k++) begin
                v[k] = t_coef'($signed(r_rows[k][i]));
            end
            w_pass1[i] = (w_mode == MODE_4) ? bfly4(v) : bfly8(v);
        end
    end

    // Row pass for output word r_k
    always_comb begin
        t_coef_row va, vb, pa, pb, qa;
        logic [2:0] ca, cb;
        ca = {r_k[1:0], 1'b0};
        cb = {r_k[1:0], 1'b1};
        for (int k = 0; k < 8; k++) begin
            va[k] = r_mid[k][r_k];
            pa[k] = r_mid[k][ca];
            pb[k] = r_mid[k][cb];
        end
        qa = bfly4(pa);
        vb = bfly4(pb);
        if (w_mode == MODE_4) begin
            w_pass2 = {vb[3:0], qa[3:0]};
        end else begin
            w_pass2 = bfly8(va);
        end
    end

    // Quadrant combine butterfly with floor halving or quartering
    always_comb begin
        logic signed [16:0] a0, a1, a2, a3, b0, b1, b2, b3;
        for (int n = 0; n < LANES; n++) begin
            a0 = 17'($signed(r_acc[0][n]));
            a1 = 17'($signed(r_acc[1][n]));
            a2 = 17'($signed(r_acc[2][n]));
            a3 = 17'($signed(r_acc[3][n]));
            b0 = r_phase2 ? (a0 + a1) >>> 2 : (a0 + a1) >>> 1;
            b1 = r_phase2 ? (a0 - a1) >>> 2 : (a0 - a1) >>> 1;
            b2 = r_phase2 ? (a2 + a3) >>> 2 : (a2 + a3) >>> 1;
            b3 = r_phase2 ? (a2 - a3) >>> 2 : (a2 - a3) >>> 1;
            w_comb[0][n] = 16'(b0 + b2);
            w_comb[1][n] = 16'(b1 + b3);
            w_comb[2][n] = 16'(b0 - b2);
            w_comb[3][n] = 16'(b1 - b3);
        end
    end

    // Handshakes
    assign w_out_free  = !r_m_valid || m_tready;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign s_tready    = (r_state == S_IDLE) && !i_cfg_valid && w_out_free;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_s_acc     = s_tvalid && s_tready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_seg     = r_seg;
        n_grp     = r_grp;
        n_ready   = r_ready;
        n_k       = r_k;
        n_tile    = r_tile;
        n_g       = r_g;
        n_j       = r_j;
        n_phase2  = r_phase2;
        n_m_valid = r_m_valid && !m_tready;
        res_we     = 1'b0;
        res_waddr  = r_seg[RES_AW-1:0];
        res_wdata  = w_clamped;
        res_raddr  = w_tile_addr[RES_AW-1:0];
        coef_we    = 1'b0;
        coef_waddr = w_row_addr[COEF_AW-1:0];
        coef_wdata = w_pass2;
        coef_raddr = r_grp[COEF_AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    n_mode  = i_cfg_data;
                    n_seg   = '0;
                    n_grp   = '0;
                    n_ready = 1'b0;
                end else if (w_s_acc && s_tuser == CMD_LOAD) begin
                    res_we = 1'b1;
                    if (r_seg[6:0] == w_seg_last) begin
                        n_seg   = '0;
                        n_k     = '0;
                        n_tile  = '0;
                        n_state = S_TLOAD;
                    end else begin
                        n_seg = r_seg + 8'd1;
                    end
                end else if (w_s_acc) begin
                    if (r_ready) begin
                        n_state = S_RDWAIT;
                    end else begin
                        n_m_valid = 1'b1;
                    end
                end
            end
            S_RDWAIT: begin
                n_m_valid = 1'b1;
                n_state   = S_IDLE;
                if (r_grp == w_grp_last) begin
                    n_grp   = '0;
                    n_ready = 1'b0;
                end else begin
                    n_grp = r_grp + 7'd1;
                end
            end
            S_TLOAD: begin
                if (r_k == w_k_last) begin
                    n_state = S_TWAIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_TWAIT: begin
                n_state = S_TPASS;
            end
            S_TPASS: begin
                n_k     = '0;
                n_state = S_TWRITE;
            end
            S_TWRITE: begin
                coef_we = 1'b1;
                if (r_k == w_i_last) begin
                    n_k = '0;
                    if (r_tile != w_tile_last) begin
                        n_tile  = r_tile + 4'd1;
                        n_state = S_TLOAD;
                    end else if (w_mode == MODE_16 || w_mode == MODE_32) begin
                        n_g      = '0;
                        n_j      = '0;
                        n_phase2 = 1'b0;
                        n_state  = S_CREAD;
                    end else begin
                        n_grp   = '0;
                        n_ready = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_CREAD: begin
                coef_raddr = w_comb_addr[COEF_AW-1:0];
                if (r_j == 2'd3) begin
                    n_state = S_CWAIT;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            S_CWAIT: begin
                n_j     = '0;
                n_state = S_CWRITE;
            end
            S_CWRITE: begin
                coef_we    = 1'b1;
                coef_waddr = w_comb_addr[COEF_AW-1:0];
                coef_wdata = w_comb[r_j];
                if (r_j == 2'd3) begin
                    n_j = '0;
                    if (r_phase2 ? (r_g == 5'd31) : (r_g == w_g_last)) begin
                        if (!r_phase2 && w_mode == MODE_32) begin
                            n_phase2 = 1'b1;
                            n_g      = '0;
                            n_state  = S_CREAD;
                        end else begin
                            n_grp   = '0;
                            n_ready = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_g     = r_g + 5'd1;
                        n_state = S_CREAD;
                    end
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_8;
            r_seg     <= '0;
            r_grp     <= '0;
            r_ready   <= 1'b0;
            r_k       <= '0;
            r_tile    <= '0;
            r_g       <= '0;
            r_j       <= '0;
            r_phase2  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_seg     <= n_seg;
            r_grp     <= n_grp;
            r_ready   <= n_ready;
            r_k       <= n_k;
            r_tile    <= n_tile;
            r_g       <= n_g;
            r_j       <= n_j;
            r_phase2  <= n_phase2;
            r_m_valid <= n_m_valid;
        end
    end

    // Capture memory read data and results
    always_ff @(posedge i_clk) begin
        if (r_state == S_TLOAD && r_k != 3'd0) begin
            r_rows[r_k - 3'd1] <= res_rdata;
        end
        if (r_state == S_TWAIT) begin
            r_rows[w_k_last] <= res_rdata;
        end
        if (r_state == S_TPASS) begin
            r_mid <= w_pass1;
        end
        if (r_state == S_CREAD && r_j != 2'd0) begin
            r_acc[r_j - 2'd1] <= coef_rdata;
        end
        if (r_state == S_CWAIT) begin
            r_acc[3] <= coef_rdata;
        end
        if (r_state == S_RDWAIT) begin
            r_m_data   <= coef_rdata;
            r_m_last   <= (r_grp == w_grp_last);
            r_m_status <= 1'b0;
        end else if (r_state == S_IDLE && !w_cfg_acc && w_s_acc && s_tuser == CMD_READ
                     && !r_ready) begin
            r_m_data   <= '0;
            r_m_last   <= 1'b0;
            r_m_status <= 1'b1;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;
    assign m_tuser  = r_m_status;

endmodule

FILE: tb/tb_hadamard_2d_transform_core.sv
// Self-checking testbench for the 2D Hadamard transform core: predictor, driver, monitor.
module tb_hadamard_2d_transform_core;
    import hadt_pkg::*;

    localparam int MEM_DEPTH  = 1024;
    localparam int SETTLE_CYC = 1000;
    localparam int STALL_MAX  = 20000;

    typedef struct {
        logic       cmd;
        logic [8:0] res [8];
    } t_seg_req;

    typedef struct {
        logic [15:0] coef [8];
        logic        last;
        logic        status;
    } t_coef_grp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_data = MODE_8;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;   // residual_0 .. residual_7, 9 bits each
    logic         s_tuser = CMD_LOAD;   // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;   // coef_0 .. coef_7, 16 bits each
    logic         m_tlast;   // last_group
    logic         m_tuser;   // status

    hadamard_2d_transform_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Pending requests, expected coefficient groups and run bookkeeping
    t_seg_req  req_q [$];
    t_coef_grp grp_q [$];
    t_seg_req  req_cur;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        err_cnt       = 0;
    int        req_cnt       = 0;
    int        grp_cnt       = 0;
    int        blk_cnt       = 0;
    int        stall_cnt     = 0;

    // Predictor state
    int         res_mem  [MEM_DEPTH];
    int         coef_mem [MEM_DEPTH];
    logic [1:0] size_mode = MODE_8;
    int         segs_in   = 0;
    int         grps_out  = 0;
    bit         blk_ready = 0;

    function automatic int side_of(logic [1:0] m);
        return 4 << m;
    endfunction

    function automatic void wht8(input int v [8], output int o [8]);
        int b [8];
        int c [8];
        for (int n = 0; n < 4; n++) begin
            b[2*n]   = v[2*n] + v[2*n+1];
            b[2*n+1] = v[2*n] - v[2*n+1];
        end
        c[0] = b[0] + b[2]; c[1] = b[1] + b[3]; c[2] = b[0] - b[2]; c[3] = b[1] - b[3];
        c[4] = b[4] + b[6]; c[5] = b[5] + b[7]; c[6] = b[4] - b[6]; c[7] = b[5] - b[7];
        o[0] = c[0] + c[4]; o[7] = c[1] + c[5]; o[3] = c[2] + c[6]; o[4] = c[3] + c[7];
        o[2] = c[0] - c[4]; o[6] = c[1] - c[5]; o[1] = c[2] - c[6]; o[5] = c[3] - c[7];
    endfunction

    function automatic void wht4(input int v [4], output int o [4]);
        int b0, b1, b2, b3;
        b0 = (v[0] + v[1]) >>> 1;
        b1 = (v[0] - v[1]) >>> 1;
        b2 = (v[2] + v[3]) >>> 1;
        b3 = (v[2] - v[3]) >>> 1;
        o[0] = b0 + b2; o[1] = b1 + b3; o[2] = b0 - b2; o[3] = b1 - b3;
    endfunction

    function automatic void xform4();
        int mid [16];
        int v [4];
        int o [4];
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) v[k] = res_mem[k*4 + i];
            wht4(v, o);
            for (int k = 0; k < 4; k++) mid[4*i + k] = o[k];
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) v[k] = mid[i + 4*k];
            wht4(v, o);
            for (int k = 0; k < 4; k++) coef_mem[4*i + k] = o[k];
        end
    endfunction

    function automatic void xform8(int r0, int c0, int side, int base);
        int mid [64];
        int v [8];
        int o [8];
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 8; k++) v[k] = res_mem[((r0 + k)*side + c0 + i) % MEM_DEPTH];
            wht8(v, o);
            for (int k = 0; k < 8; k++) mid[8*i + k] = o[k];
        end
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 8; k++) v[k] = mid[i + 8*k];
            wht8(v, o);
            for (int k = 0; k < 8; k++) coef_mem[base + 8*i + k] = o[k];
        end
    endfunction

    // Quadrant merge with floor-rounded scaling
    function automatic void merge_quads(int base, int n, int k);
        int a0, a1, a2, a3, b0, b1, b2, b3;
        for (int i = 0; i < n; i++) begin
            a0 = coef_mem[base + i];       a1 = coef_mem[base + i + n];
            a2 = coef_mem[base + i + 2*n]; a3 = coef_mem[base + i + 3*n];
            b0 = (a0 + a1) >>> k; b1 = (a0 - a1) >>> k;
            b2 = (a2 + a3) >>> k; b3 = (a2 - a3) >>> k;
            coef_mem[base + i]       = b0 + b2;
            coef_mem[base + i + n]   = b1 + b3;
            coef_mem[base + i + 2*n] = b0 - b2;
            coef_mem[base + i + 3*n] = b1 - b3;
        end
    endfunction

    function automatic void xform16(int r0, int c0, int side, int base);
        for (int q = 0; q < 4; q++) xform8(r0 + (q >> 1)*8, c0 + (q & 1)*8, side, base + 64*q);
        merge_quads(base, 64, 1);
    endfunction

    function automatic void xform_block(int side);
        case (side)
            4:  xform4();
            8:  xform8(0, 0, 8, 0);
            16: xform16(0, 0, 16, 0);
            default: begin
                for (int q = 0; q < 4; q++) xform16((q >> 1)*16, (q & 1)*16, 32, 256*q);
                merge_quads(0, 256, 2);
            end
        endcase
    endfunction

    // Advance the predictor by one accepted request; queue a group for reads
    function automatic void predict_req(t_seg_req rq);
        int        side, per_row, n_segs, lanes, row, col, v, n_grps;
        t_coef_grp g;
        side   = side_of(size_mode);
        n_grps = side*side/LANES;
        if (rq.cmd == CMD_LOAD) begin
            per_row = (side <= LANES) ? 1 : side/LANES;
            n_segs  = (side == 4) ? 4 : side*side/LANES;
            lanes   = (side < LANES) ? side : LANES;
            row     = segs_in / per_row;
            col     = (segs_in % per_row) * LANES;
            for (int j = 0; j < lanes; j++) begin
                v = int'($signed(rq.res[j]));
                if (v == -256) v = -255;
                res_mem[(row*side + col + j) % MEM_DEPTH] = v;
            end
            segs_in++;
            if (segs_in >= n_segs) begin
                xform_block(side);
                segs_in   = 0;
                grps_out  = 0;
                blk_ready = 1;
            end
            return;
        end
        if (!blk_ready) begin
            foreach (g.coef[j]) g.coef[j] = '0;
            g.last   = 1'b0;
            g.status = 1'b1;
        end else begin
            foreach (g.coef[j]) g.coef[j] = 16'(coef_mem[(grps_out*8 + j) % MEM_DEPTH]);
            g.status = 1'b0;
            g.last   = (grps_out + 1 >= n_grps);
            if (g.last) begin
                grps_out  = 0;
                blk_ready = 0;
            end else begin
                grps_out++;
            end
        end
        grp_q.push_back(g);
    endfunction

    // Drive requests from the pending queue, holding each until taken
    always @(posedge i_clk) begin
        t_seg_req nxt;
        logic     nv;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_req(req_cur);
                req_cnt++;
                nv = 1'b0;
            end
            if (!nv && req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt     = req_q.pop_front();
                req_cur = nxt;
                nv      = 1'b1;
                s_tuser <= nxt.cmd;
                for (int j = 0; j < 8; j++) s_tdata[9*j +: 9] <= nxt.res[j];
            end
            s_tvalid <= nv;
        end
    end

    // Check each accepted group against the oldest expectation
    always @(posedge i_clk) begin
        t_coef_grp g;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                grp_cnt++;
                if (grp_q.size() == 0) begin
                    $error("unexpected coefficient group");
                    err_cnt++;
                end else begin
                    g = grp_q.pop_front();
                    for (int j = 0; j < 8; j++) begin
                        if (m_tdata[16*j +: 16] !== g.coef[j]) begin
                            $error("coef_%0d: expected %0d, got %0d", j, $signed(g.coef[j]),
                                   $signed(m_tdata[16*j +: 16]));
                            err_cnt++;
                        end
                    end
                    if (m_tlast !== g.last) begin
                        $error("last_group: expected %0d, got %0d", g.last, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser !== g.status) begin
                        $error("status: expected %0d, got %0d", g.status, m_tuser);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Stop on a long stretch with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [8:0] rand_res();
        case ($urandom_range(19))
            0:       return 9'h100;   // -256, clamped by the block
            1:       return 9'h0FF;
            2:       return 9'h101;
            3:       return 9'h000;
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    function automatic void push_req(logic cmd, logic [8:0] fill, bit rnd);
        t_seg_req rq;
        rq.cmd = cmd;
        foreach (rq.res[j]) rq.res[j] = rnd ? rand_res() : fill;
        req_q.push_back(rq);
    endfunction

    // Wait for all traffic to drain plus the transform latency
    task automatic drain();
        while (req_q.size() != 0 || s_tvalid || grp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_size(logic [1:0] m);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_mode = m;
        segs_in   = 0;
        grps_out  = 0;
        blk_ready = 0;
    endtask

    // Queue random load segments with stray reads, then reads of the whole block plus one, or of half
    task automatic queue_block(logic [1:0] m, int n_load, bit read_all);
        int side, n_grps;
        side   = side_of(m);
        n_grps = side*side/LANES;
        for (int s = 0; s < n_load; s++) begin
            if ($urandom_range(99) < 8) push_req(CMD_READ, '0, 1);
            push_req(CMD_LOAD, '0, 1);
        end
        if (n_load == ((side == 4) ? 4 : n_grps)) blk_cnt++;
        for (int r = 0; r < (read_all ? n_grps + 1 : n_grps/2); r++) push_req(CMD_READ, '0, 1);
    endtask

    task automatic run_era(logic [1:0] modes [$]);
        int nseg;
        foreach (modes[b]) begin
            if (modes[b] != size_mode || $urandom_range(1)) write_size(modes[b]);
            nseg = (modes[b] == MODE_4) ? 4 : side_of(modes[b])*side_of(modes[b])/LANES;
            queue_block(modes[b], nseg, $urandom_range(9) < 7);
        end
    endtask

    initial begin
        foreach (res_mem[i]) begin
            res_mem[i]  = 0;
            coef_mem[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: read before ready, extreme rows at the reset size, full read-out
        push_req(CMD_READ, '0, 0);
        push_req(CMD_LOAD, 9'h0FF, 0);
        push_req(CMD_LOAD, 9'h101, 0);
        push_req(CMD_LOAD, 9'h100, 0);
        push_req(CMD_LOAD, 9'h000, 0);
        push_req(CMD_LOAD, 9'h0FF, 0);
        push_req(CMD_LOAD, 9'h100, 0);
        push_req(CMD_LOAD, 9'h1FF, 0);
        push_req(CMD_LOAD, 9'h001, 0);
        for (int r = 0; r < 9; r++) push_req(CMD_READ, '0, 0);
        blk_cnt++;

        // Sender sparse, receiver mostly stalled
        send_idle_pct = 31;
        recv_idle_pct = 82;
        run_era('{MODE_4, MODE_8, MODE_16, MODE_4});
        // Partial block, then a size write abandons it
        write_size(MODE_16);
        queue_block(MODE_16, 10, 0);
        drain();

        // Sender mostly idle, receiver sparse
        send_idle_pct = 82;
        recv_idle_pct = 31;
        run_era('{MODE_32, MODE_8, MODE_4});
        drain();

        // Back-to-back traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_era('{MODE_16, MODE_16, MODE_4, MODE_8, MODE_8, MODE_4});
        drain();

        $display("Covered %0d requests and %0d coefficient groups over %0d full blocks",
                 req_cnt, grp_cnt, blk_cnt);
        $display("of sizes 4x4 to 32x32, with partial and overlapped loads.");
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
